[rtl/core/swm_pkg.sv]
// Shared types and defaults for the sliding-window median filter.
package swm_pkg;

    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int SAMPLE_FIELD_W = 32;
    localparam int MEDIAN_FIELD_W = 33;
    localparam int SIZE_FIELD_W   = 7;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 40;

    localparam logic [SIZE_FIELD_W-1:0] SIZE_RESET = 7'd3;

    // Per-word control broadcast from the top level to every cell.
    typedef struct packed {
        logic load;   // a word is accepted this cycle
        logic evict;  // the window is full, the oldest sample leaves
    } swm_ctrl_t;

endpackage

[rtl/core/swm_cell.sv]
// One cell of the sorted chain: holds one sample and its age.
module swm_cell #(
    parameter int IDX          = 0,
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int CW           = $clog2(MAX_WINDOW + 1),
    parameter int AW           = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                           aclk,
    input  swm_pkg::swm_ctrl_t             ctrl,
    input  logic [CW-1:0]                  fill,
    input  logic [AW-1:0]                  oldest_age,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] evict_val,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_val,
    input  logic [AW-1:0]                  prev_age,
    input  logic                           prev_gt,
    input  logic                           prev_shift,
    input  logic signed [SAMPLE_WIDTH-1:0] next_val,
    input  logic [AW-1:0]                  next_age,
    input  logic                           next_gt,
    output logic signed [SAMPLE_WIDTH-1:0] val,
    output logic [AW-1:0]                  age,
    output logic                           gt,
    output logic                           shift,
    output logic [SAMPLE_WIDTH-1:0]        match_val
);

    logic signed [SAMPLE_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]                  age_reg, age_next;
    logic                           valid;
    logic                           gt_here;
    logic                           gt_prev;
    logic signed [SAMPLE_WIDTH-1:0] keep_val, from_prev_val;
    logic [AW-1:0]                  keep_age, from_prev_age;

    assign valid = CW'(IDX) < fill;
    // Cells past the fill level behave as larger than any sample.
    assign gt    = !valid || (val_reg > sample);
    assign shift = ctrl.evict && (!valid || (val_reg >= evict_val));
    assign match_val = (valid && age_reg == oldest_age) ? val_reg : '0;

    // Order after the oldest word is taken out: cells at or above it slide down.
    assign keep_val      = shift ? next_val : val_reg;
    assign keep_age      = shift ? next_age : age_reg;
    assign from_prev_val = prev_shift ? val_reg : prev_val;
    assign from_prev_age = prev_shift ? age_reg : prev_age;
    assign gt_here       = shift ? next_gt : gt;
    assign gt_prev       = prev_shift ? gt : prev_gt;

    always_comb begin
        if (!gt_here) begin
            val_next = keep_val;
            age_next = keep_age + 1'b1;
        end else if (gt_prev) begin
            val_next = from_prev_val;
            age_next = from_prev_age + 1'b1;
        end else begin
            val_next = sample;
            age_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

[rtl/core/swm_chain.sv]
// Row of sorting cells kept in ascending order, with the oldest-sample lookup.
module swm_chain #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int CW           = $clog2(MAX_WINDOW + 1),
    parameter int AW           = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                                     aclk,
    input  swm_pkg::swm_ctrl_t                       ctrl,
    input  logic [CW-1:0]                            fill,
    input  logic [AW-1:0]                            oldest_age,
    input  logic signed [SAMPLE_WIDTH-1:0]           sample,
    output logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0]  cell_vals
);

    logic signed [SAMPLE_WIDTH-1:0] val   [MAX_WINDOW+1];
    logic [AW-1:0]                  age   [MAX_WINDOW+1];
    logic                           gt    [MAX_WINDOW+1];
    logic                           shift [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0]        match_val [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0]        evict_bits;

    // Boundary beyond the last cell: always larger, never supplies data.
    assign val[MAX_WINDOW]   = '0;
    assign age[MAX_WINDOW]   = '0;
    assign gt[MAX_WINDOW]    = 1'b1;

    // Only one held sample carries the oldest age, so an OR picks it out.
    always_comb begin
        evict_bits = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            evict_bits = evict_bits | match_val[i];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            logic signed [SAMPLE_WIDTH-1:0] p_val;
            logic [AW-1:0]                  p_age;
            logic                           p_gt;
            logic                           p_shift;

            if (gi == 0) begin : g_first
                assign p_val   = '0;
                assign p_age   = '0;
                assign p_gt    = 1'b0;
                assign p_shift = 1'b0;
            end else begin : g_rest
                assign p_val   = val[gi-1];
                assign p_age   = age[gi-1];
                assign p_gt    = gt[gi-1];
                assign p_shift = shift[gi-1];
            end

            swm_cell #(
                .IDX          (gi),
                .MAX_WINDOW   (MAX_WINDOW),
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .CW           (CW),
                .AW           (AW)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .fill       (fill),
                .oldest_age (oldest_age),
                .sample     (sample),
                .evict_val  (evict_bits),
                .prev_val   (p_val),
                .prev_age   (p_age),
                .prev_gt    (p_gt),
                .prev_shift (p_shift),
                .next_val   (val[gi+1]),
                .next_age   (age[gi+1]),
                .next_gt    (gt[gi+1]),
                .val        (val[gi]),
                .age        (age[gi]),
                .gt         (gt[gi]),
                .shift      (shift[gi]),
                .match_val  (match_val[gi])
            );

            assign cell_vals[gi] = val[gi];
        end
    endgenerate

endmodule

[rtl/core/sliding_window_median.sv]
// Sliding-window median filter: top level with handshakes, fill count and output register.
// A median word reaches m_tdata once its input word has updated the cell chain and the
// median sum has been registered. Throughput: one word per cycle while m_tready stays high;
// the sorted cell chain updates as a word is taken and the median add is registered after it.
// Reset (aresetn low, synchronous) empties the window, sets window_size to 3
// and drops m_tvalid; cell contents are left as they are.
module sliding_window_median #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swm_pkg::S_TDATA_W-1:0]      s_tdata,   // [31:0] sample
    input  logic                               s_tuser,   // [0] restart
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swm_pkg::M_TDATA_W-1:0]      m_tdata,   // [32:0] median_twice, [39:33] zero
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swm_pkg::SIZE_FIELD_W-1:0]   cfg_data   // [6:0] window_size
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int OW = SAMPLE_WIDTH + 1;

    logic [swm_pkg::SIZE_FIELD_W-1:0] size_reg;
    logic [CW-1:0]                    fill_reg, fill_next;
    logic                             pend_reg, pend_next;
    logic                             out_valid_reg, out_valid_next;
    logic [OW-1:0]                    out_data_reg, out_data_next;

    logic [31:0]                      size32;
    logic [31:0]                      weff32;
    logic [CW-1:0]                    weff;
    logic [CW-1:0]                    weff_m1;
    logic [AW-1:0]                    lo_idx, hi_idx;
    logic [CW-1:0]                    fill_eff;
    logic                             accept;
    logic                             out_free;
    swm_pkg::swm_ctrl_t               ctrl;
    logic signed [SAMPLE_WIDTH-1:0]   sample;
    logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] cell_vals;
    logic signed [OW-1:0]             mid_lo, mid_hi, median_sum;

    assign size32 = 32'(size_reg);
    always_comb begin
        if (size32 == 32'd0) begin
            weff32 = 32'd1;
        end else if (size32 > 32'(MAX_WINDOW)) begin
            weff32 = 32'(MAX_WINDOW);
        end else begin
            weff32 = size32;
        end
    end
    assign weff    = weff32[CW-1:0];
    assign weff_m1 = weff - 1'b1;
    assign lo_idx  = AW'(weff_m1 >> 1);
    assign hi_idx  = AW'(weff >> 1);

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !pend_reg || out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign sample     = s_tdata[SAMPLE_WIDTH-1:0];
    assign fill_eff   = s_tuser ? '0 : fill_reg;
    assign ctrl.load  = accept;
    assign ctrl.evict = fill_eff >= weff;

    swm_chain #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CW           (CW),
        .AW           (AW)
    ) u_chain (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .fill       (fill_eff),
        .oldest_age (AW'(weff_m1)),
        .sample     (sample),
        .cell_vals  (cell_vals)
    );

    // For an odd window both indexes point at the middle cell, giving twice its value.
    assign mid_lo     = OW'(signed'(cell_vals[lo_idx]));
    assign mid_hi     = OW'(signed'(cell_vals[hi_idx]));
    assign median_sum = mid_lo + mid_hi;

    always_comb begin
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (pend_reg && out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = median_sum;
            pend_next      = 1'b0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            fill_next = ctrl.evict ? fill_eff : fill_eff + 1'b1;
            pend_next = ((ctrl.evict ? fill_eff : fill_eff + 1'b1) == weff);
        end

        if (cfg_valid) begin
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= swm_pkg::SIZE_RESET;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                size_reg <= cfg_data;
            end
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = swm_pkg::M_TDATA_W'(out_data_reg);

endmodule

[dv/swm_checker.sv]
`timescale 1ns / 100ps
// Watches the sample, median and window-size channels, predicts each median and compares it.
module swm_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [swm_pkg::S_TDATA_W-1:0]      s_tdata,   // [31:0] sample
    input  logic                               s_tuser,   // [0] restart
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [swm_pkg::M_TDATA_W-1:0]      m_tdata,   // [32:0] median_twice, [39:33] zero
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [swm_pkg::SIZE_FIELD_W-1:0]   cfg_data,  // [6:0] window_size
    output int                                 fail_count,
    output int                                 medians_waiting,
    output int                                 samples_taken,
    output int                                 medians_checked
);

    localparam int MAX_REPORTS = 30;

    logic signed [swm_pkg::SAMPLE_FIELD_W-1:0] window_samples[$];   // oldest first
    logic [swm_pkg::MEDIAN_FIELD_W-1:0]        expected_medians[$];
    logic [swm_pkg::SIZE_FIELD_W-1:0]          size_reg;
    int                                        mismatches;
    int                                        taken;
    int                                        checked;

    assign fail_count      = mismatches;
    assign samples_taken   = taken;
    assign medians_checked = checked;

    // A size of zero acts as one sample, anything past the build limit as the limit.
    function automatic int span_of(input logic [swm_pkg::SIZE_FIELD_W-1:0] sz);
        if (sz == '0) return 1;
        if (int'(sz) > swm_pkg::MAX_WINDOW_DEF) return swm_pkg::MAX_WINDOW_DEF;
        return int'(sz);
    endfunction

    // Sorts the held samples and adds the two middle ones; for an odd span
    // both indexes land on the same middle sample.
    function automatic logic [swm_pkg::MEDIAN_FIELD_W-1:0] median_twice(input int span);
        logic signed [swm_pkg::SAMPLE_FIELD_W-1:0] ordered[swm_pkg::MAX_WINDOW_DEF];
        logic signed [swm_pkg::SAMPLE_FIELD_W-1:0] v;
        logic signed [swm_pkg::SAMPLE_FIELD_W-1:0] lo;
        logic signed [swm_pkg::SAMPLE_FIELD_W-1:0] hi;
        int i;
        int j;
        for (i = 0; i < span; i++) begin
            v = window_samples[i];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        lo = ordered[(span - 1) / 2];
        hi = ordered[span / 2];
        return {lo[swm_pkg::SAMPLE_FIELD_W-1], lo} + {hi[swm_pkg::SAMPLE_FIELD_W-1], hi};
    endfunction

    always @(posedge aclk) begin
        logic [swm_pkg::M_TDATA_W-1:0] want;
        int span;
        if (!aresetn) begin
            window_samples.delete();
            expected_medians.delete();
            size_reg   = swm_pkg::SIZE_RESET;
            mismatches = 0;
            taken      = 0;
            checked    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_medians.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: median word with none expected: expected none, got %h",
                                 $time, m_tdata);
                end else begin
                    want = swm_pkg::M_TDATA_W'(expected_medians.pop_front());
                    checked++;
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: median mismatch: expected %h, got %h",
                                     $time, want, m_tdata);
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                size_reg = cfg_data;
                window_samples.delete();
            end

            if (s_tvalid && s_tready) begin
                span = span_of(size_reg);
                taken++;
                if (s_tuser)
                    window_samples.delete();
                if (window_samples.size() >= span)
                    void'(window_samples.pop_front());
                window_samples.insert(window_samples.size(),
                                      s_tdata[swm_pkg::SAMPLE_FIELD_W-1:0]);
                if (window_samples.size() == span)
                    expected_medians.insert(expected_medians.size(), median_twice(span));
            end
        end
        medians_waiting <= expected_medians.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the sliding-window median filter; checking sits in swm_checker.
module tb_top;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    localparam int      HOLD_CYCLES  = 200;
    localparam int      SETTLE       = 4;
    localparam realtime RUN_LIMIT    = 3ms;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [swm_pkg::S_TDATA_W-1:0]      s_tdata;    // [31:0] sample
    logic                               s_tuser;    // [0] restart
    logic                               m_tvalid;
    logic                               m_tready;
    logic [swm_pkg::M_TDATA_W-1:0]      m_tdata;    // [32:0] median_twice, [39:33] zero
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [swm_pkg::SIZE_FIELD_W-1:0]   cfg_data;   // [6:0] window_size

    int  fail_count;
    int  medians_waiting;
    int  samples_taken;
    int  medians_checked;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  size_writes;

    sliding_window_median dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    swm_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .medians_waiting (medians_waiting),
        .samples_taken   (samples_taken),
        .medians_checked (medians_checked)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #RUN_LIMIT;
        $display("tb_top NOT OK");
        $finish;
    end

    // Median receiver: random stalls, or one long hold-off when asked for.
    initial begin
        int held;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default:   begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic push_sample(input logic [swm_pkg::S_TDATA_W-1:0] smp, input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Waits until every expected median has come, then lets the pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (medians_waiting != 0 || hold_req)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_window_size(input logic [swm_pkg::SIZE_FIELD_W-1:0] sz);
        cfg_valid <= 1'b1;
        cfg_data  <= sz;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        size_writes++;
    endtask

    // Mix of full-range words, tight clusters that force duplicates, and the extremes.
    function automatic logic [swm_pkg::S_TDATA_W-1:0] pick_sample();
        case ($urandom_range(0, 9)) inside
            [0:3]:   return $urandom;
            [4:6]:   return swm_pkg::S_TDATA_W'($urandom_range(0, 15)) - 32'd8;
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return swm_pkg::S_TDATA_W'($urandom_range(0, 2000)) - 32'd1000;
        endcase
    endfunction

    task automatic run_random_phase(input logic [swm_pkg::SIZE_FIELD_W-1:0] sz,
                                    input int count, input idle_mode_t mode,
                                    input int hold_at, input int drain_at);
        int i;
        int restart_pct;
        wait_drained();
        set_idling(mode);
        write_window_size(sz);
        restart_pct = (sz >= 7'd32) ? 1 : 4;
        for (i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == drain_at)
                wait_drained();
            push_sample(pick_sample(), $urandom_range(0, 99) < restart_pct);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        hold_req       = 1'b0;
        size_writes    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed words at the reset size of three: extremes, restarts, duplicates.
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b1);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'h0000_0005, 1'b1);
        push_sample(32'h0000_0005, 1'b0);
        push_sample(32'hFFFF_FFFD, 1'b0);
        push_sample(32'h0000_0005, 1'b0);
        push_sample(32'h5555_5555, 1'b0);
        push_sample(32'hAAAA_AAAA, 1'b0);
        push_sample(32'h0000_0007, 1'b0);

        // Even window: exact sums of the two middle samples at both ends of the range.
        wait_drained();
        write_window_size(7'd2);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h1234_5678, 1'b1);

        run_random_phase(7'd0,   40, IDLE_NONE, -1, -1);
        run_random_phase(7'd1,   60, IDLE_SEND, -1, -1);
        run_random_phase(7'd2,   60, IDLE_RECV, -1, -1);
        run_random_phase(7'd3,   80, IDLE_BOTH, -1, -1);
        run_random_phase(7'd4,   60, IDLE_NONE, 10, -1);
        run_random_phase(7'd5,   60, IDLE_SEND, -1, 30);
        run_random_phase(7'd8,   60, IDLE_RECV, -1, -1);
        run_random_phase(7'd7,   60, IDLE_BOTH, -1, -1);
        run_random_phase(7'd63,  90, IDLE_NONE, 70, -1);
        run_random_phase(7'd64,  80, IDLE_BOTH, -1, -1);
        run_random_phase(7'd127, 70, IDLE_SEND, -1, -1);
        run_random_phase(7'd16,  40, IDLE_RECV, -1, -1);

        wait_drained();
        repeat (10) @(negedge aclk);

        $display("Summary: %0d samples fed, %0d medians compared over %0d window-size writes",
                 samples_taken, medians_checked, size_writes);
        $display("Sizes 0 through 127, restarts, duplicate clusters, stalls on both sides");
        if (fail_count == 0 && medians_waiting == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
